[rtl/core/i2cm_pkg.sv]
package i2cm_pkg;

   localparam int unsigned CMD_W   = 2;
   localparam int unsigned ADDR_W  = 7;
   localparam int unsigned TICKS_W = 10;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned BIT_W   = 4;

   localparam int unsigned REQ_TDATA_W = 24;
   localparam int unsigned RSP_TDATA_W = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_RSVD  = 2'd3
   } cmd_type;

   // csr register indexes
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_PHASE_TICKS    = 1'b1;

   localparam logic [BIT_W-1:0] LAST_BIT = 4'd15;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'd0,
      PH_START1   = 5'd1,
      PH_START2   = 5'd2,
      PH_TX_DEVW  = 5'd3,
      PH_ACK_DEVW = 5'd4,
      PH_TX_REG   = 5'd5,
      PH_ACK_REG  = 5'd6,
      PH_TX_DATA  = 5'd7,
      PH_ACK_DATA = 5'd8,
      PH_RS0      = 5'd9,
      PH_RS1      = 5'd10,
      PH_RS2      = 5'd11,
      PH_TX_DEVR  = 5'd12,
      PH_ACK_DEVR = 5'd13,
      PH_RX       = 5'd14,
      PH_ACK_LAST = 5'd15,
      PH_STOP0    = 5'd16,
      PH_STOP1    = 5'd17,
      PH_STOP2    = 5'd18
   } phase_type;

   typedef struct packed {
      phase_type          phase;
      logic [BIT_W-1:0]   bit_index;
      logic [BYTE_W-1:0]  tx_shift;
      logic [BYTE_W-1:0]  rx_shift;
      logic [TICKS_W-1:0] tick_count;
      logic               is_read;
      logic [BYTE_W-1:0]  held_reg_addr;
      logic [BYTE_W-1:0]  held_write_data;
      logic               ack_sample;
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] reg_addr;
      logic [BYTE_W-1:0] write_data;
      logic              sda_in;
   } item_type;

   typedef struct packed {
      logic              last_ack;
      logic [BYTE_W-1:0] read_data;
      logic              done_res;
      logic              busy_res;
      logic              sda_pull_low;
      logic              scl_level;
   } result_type;

endpackage

[rtl/core/i2cm_step.sv]
// One sequencer tick: next bus state and bus levels from the current state,
// the registered request and the configuration.
module i2cm_step
   import i2cm_pkg::*;
(
   input  state_type                 cur,
   input  item_type                  item,
   input  logic [ADDR_W-1:0]         device_address,
   input  logic [TICKS_W-1:0]        phase_ticks,
   output state_type                 nxt,
   output result_type                res
);

   function automatic state_type enter_f(state_type s, phase_type ph, logic [BYTE_W-1:0] load);
      state_type r;
      r            = s;
      r.phase      = ph;
      r.bit_index  = '0;
      r.tick_count = '0;
      r.tx_shift   = load;
      return r;
   endfunction

   logic [TICKS_W-1:0] len;
   logic [TICKS_W:0]   tick_inc;

   assign len      = (phase_ticks == '0) ? TICKS_W'(1) : phase_ticks;
   assign tick_inc = {1'b0, cur.tick_count} + (TICKS_W+1)'(1);

   always_comb begin
      state_type s;
      logic      high_half;
      logic      is_tx;
      logic      is_ack;
      logic      half_end;
      logic      scl;
      logic      pull;
      logic      done;

      s = cur;
      if (s.phase > PH_STOP2) begin
         s.phase = PH_IDLE;
      end
      if ((s.phase == PH_IDLE) &&
          ((item.cmd == CMD_WRITE) || (item.cmd == CMD_READ))) begin
         s.is_read         = (item.cmd == CMD_READ);
         s.held_reg_addr   = item.reg_addr;
         s.held_write_data = item.write_data;
         s = enter_f(s, PH_START1, '0);
      end

      high_half = s.bit_index[0];
      is_tx     = s.phase inside {PH_TX_DEVW, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR};
      is_ack    = s.phase inside {PH_ACK_DEVW, PH_ACK_REG, PH_ACK_DATA,
                                  PH_ACK_DEVR, PH_ACK_LAST};
      half_end  = tick_inc >= {1'b0, len};
      scl       = 1'b1;
      pull      = 1'b0;
      done      = 1'b0;

      // bus levels come from the phase at the start of the tick
      if (is_tx) begin
         scl  = high_half;
         pull = ~s.tx_shift[BYTE_W-1];
      end else if (is_ack || (s.phase == PH_RX)) begin
         scl = high_half;
      end else begin
         case (s.phase)
            PH_START2, PH_RS2, PH_STOP1: pull = 1'b1;
            PH_RS0: scl = 1'b0;
            PH_STOP0: begin
               scl  = 1'b0;
               pull = 1'b1;
            end
            default: ;
         endcase
      end

      res.busy_res = (s.phase != PH_IDLE);

      if (s.phase != PH_IDLE) begin
         if (!half_end) begin
            s.tick_count = tick_inc[TICKS_W-1:0];
         end else if (is_tx || (s.phase == PH_RX)) begin
            if (high_half) begin
               s.tx_shift = {s.tx_shift[BYTE_W-2:0],
                             (s.phase == PH_RX) ? item.sda_in : 1'b0};
            end
            if (s.bit_index < LAST_BIT) begin
               s.bit_index  = s.bit_index + BIT_W'(1);
               s.tick_count = '0;
            end else begin
               if (s.phase == PH_RX) begin
                  s.rx_shift = s.tx_shift;
               end
               s = enter_f(s, phase_type'(s.phase + 5'd1), '0);
            end
         end else if (is_ack) begin
            if (s.bit_index == '0) begin
               s.bit_index  = BIT_W'(1);
               s.tick_count = '0;
            end else begin
               s.ack_sample = item.sda_in;
               case (s.phase)
                  PH_ACK_DEVW: s = enter_f(s, PH_TX_REG, s.held_reg_addr);
                  PH_ACK_REG: begin
                     if (s.is_read) begin
                        s = enter_f(s, PH_RS0, '0);
                     end else begin
                        s = enter_f(s, PH_TX_DATA, s.held_write_data);
                     end
                  end
                  PH_ACK_DEVR: s = enter_f(s, PH_RX, '0);
                  default: s = enter_f(s, PH_STOP0, '0);
               endcase
            end
         end else begin
            case (s.phase)
               PH_START2: s = enter_f(s, PH_TX_DEVW, {device_address, 1'b0});
               PH_RS2:    s = enter_f(s, PH_TX_DEVR, {device_address, 1'b1});
               PH_STOP2: begin
                  s    = enter_f(s, PH_IDLE, '0);
                  done = 1'b1;
               end
               default: s = enter_f(s, phase_type'(s.phase + 5'd1), '0);
            endcase
         end
      end

      nxt              = s;
      res.scl_level    = scl;
      res.sda_pull_low = pull;
      res.done_res     = done;
      res.read_data    = s.rx_shift;
      res.last_ack     = s.ack_sample;
   end

endmodule

[rtl/core/i2c_master_register_access_core.sv]
// I2C master, one single-register write or read per command.
// req channel: one request is one sequencer tick carrying a command, the
//   register address, the write byte and the sampled SDA level. Command 1
//   starts a write, 2 starts a read; commands arriving while busy are
//   ignored like a plain tick.
// rsp channel: exactly one response per request: SCL level, SDA pull-down,
//   busy, done pulse, last read byte and last acknowledge sample.
// csr port: index 0 device address, index 1 ticks per SCL half period.
//   Write only while no request is in flight.
// Pipeline: a request lands in the input register on acceptance and its
//   response in the output register when it advances. Throughput: one
//   request per cycle while responses are taken; the sequencer state
//   update is a single pass of logic between the two registers.
// Stall: when rsp_tready is low the response holds, the input register
//   keeps one more request, then req_tready drops; nothing is lost.
// Reset: sequencer goes idle with cleared shifters, device address 104,
//   8 ticks per half period, both registers empty.
module i2c_master_register_access_core
   import i2cm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // cmd[1:0], reg_addr[9:2], write_data[17:10], sda_in[18], zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // scl_level[0], sda_pull_low[1], busy_res[2], done_res[3],
   // read_data[11:4], last_ack[12], zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,

   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [TICKS_W-1:0]     csr_wdata
);

   // configuration
   logic [ADDR_W-1:0]  dev_addr_ff;
   logic [TICKS_W-1:0] phase_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= ADDR_W'(104);
         phase_ticks_ff <= TICKS_W'(8);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS: dev_addr_ff    <= csr_wdata[ADDR_W-1:0];
            CSR_PHASE_TICKS:    phase_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   logic     in_valid_ff;
   item_type in_item_ff;
   logic     advance;

   assign advance    = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff.cmd        <= req_tdata[1:0];
         in_item_ff.reg_addr   <= req_tdata[9:2];
         in_item_ff.write_data <= req_tdata[17:10];
         in_item_ff.sda_in     <= req_tdata[18];
      end
   end

   // sequencer state, advanced once per request
   state_type  state_ff;
   state_type  state_in;
   result_type res_in;

   i2cm_step u_step (
      .cur            (state_ff),
      .item           (in_item_ff),
      .device_address (dev_addr_ff),
      .phase_ticks    (phase_ticks_ff),
      .nxt            (state_in),
      .res            (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, default: '0};
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // output register
   logic       rsp_valid_ff;
   result_type rsp_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_res_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_res_ff};

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

// I2C single-register access master: stream-level check.
// Every request is one sequencer tick, and every tick returns one response
// with the bus levels and status. A local model of the sequencer predicts
// each response when its request is accepted.
module testbench;
   import i2cm_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
   localparam int unsigned DRAIN_CYCLES = 8;     // covers the port latency, with margin
   localparam int unsigned RSP_W        = $bits(result_type);
   localparam int unsigned REQ_PAD_W    = REQ_TDATA_W - CMD_W - 2 * BYTE_W - 1;

   // quiet bus, nothing received yet
   localparam result_type IDLE_BUS   = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
   // first tick of an access: busy, SCL and SDA still released
   localparam result_type START_TICK = '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1};

   typedef struct {
      item_type   req;
      bit         typed;   // 1: want is fixed, 0: use the model
      result_type want;
   } directed_row;

   typedef struct {
      logic [ADDR_W-1:0]  dev;
      logic [TICKS_W-1:0] ticks;
      int unsigned        count;
   } config_phase;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en  = 1'b0;
   logic                   csr_index  = CSR_DEVICE_ADDRESS;
   logic [TICKS_W-1:0]     csr_wdata  = '0;

   // Sequencer model state, reset values
   phase_type          seq_ph         = PH_IDLE;
   logic [BIT_W-1:0]   bit_pos        = '0;
   logic [BYTE_W-1:0]  shift_byte     = '0;
   logic [BYTE_W-1:0]  rx_byte        = '0;
   logic [TICKS_W-1:0] half_count     = '0;
   logic               access_is_read = 1'b0;
   logic [BYTE_W-1:0]  latched_reg    = '0;
   logic [BYTE_W-1:0]  latched_data   = '0;
   logic               ack_level      = 1'b0;
   logic [ADDR_W-1:0]  cfg_dev_addr   = 7'd104;
   logic [TICKS_W-1:0] cfg_half_ticks = 10'd8;

   result_type  pending_bus_levels[$];
   int unsigned mismatch_count = 0;
   bit          hold_request   = 1'b0;

   // Opening requests, run at reset config (8 ticks per half):
   // quiet-bus ticks with field extremes, reserved command on an idle bus,
   // then a write start followed by commands that arrive while busy.
   directed_row opening_rows[14] = '{
      '{'{CMD_TICK,  8'h00, 8'h00, 1'b0}, 1'b1, IDLE_BUS},
      '{'{CMD_TICK,  8'hFF, 8'hFF, 1'b1}, 1'b1, IDLE_BUS},
      '{'{CMD_RSVD,  8'hFF, 8'hFF, 1'b1}, 1'b1, IDLE_BUS},
      '{'{CMD_RSVD,  8'h00, 8'h00, 1'b0}, 1'b1, IDLE_BUS},
      '{'{CMD_WRITE, 8'hFF, 8'h00, 1'b1}, 1'b1, START_TICK},
      '{'{CMD_READ,  8'h00, 8'hFF, 1'b0}, 1'b0, IDLE_BUS},
      '{'{CMD_WRITE, 8'h5A, 8'hA5, 1'b1}, 1'b0, IDLE_BUS},
      '{'{CMD_RSVD,  8'hFF, 8'hFF, 1'b0}, 1'b0, IDLE_BUS},
      '{'{CMD_TICK,  8'h00, 8'h00, 1'b1}, 1'b0, IDLE_BUS},
      '{'{CMD_READ,  8'hA5, 8'h5A, 1'b0}, 1'b0, IDLE_BUS},
      '{'{CMD_TICK,  8'hFF, 8'h00, 1'b1}, 1'b0, IDLE_BUS},
      '{'{CMD_TICK,  8'h00, 8'hFF, 1'b0}, 1'b0, IDLE_BUS},
      '{'{CMD_TICK,  8'h00, 8'h00, 1'b1}, 1'b0, IDLE_BUS},
      '{'{CMD_TICK,  8'hFF, 8'hFF, 1'b0}, 1'b0, IDLE_BUS}
   };

   // Config sweep: both registers per step, address and tick extremes,
   // zero ticks (treated as one), and a short stint at the slowest rate.
   config_phase sweep[6] = '{
      '{7'h7F, 10'd1,    350},
      '{7'h00, 10'd2,    300},
      '{7'h55, 10'd0,    300},
      '{7'h68, 10'd1023, 400},
      '{7'h2A, 10'd1,    300},
      '{7'h13, 10'd3,    250}
   };

   i2c_master_register_access_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin : reset_gen
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Sequencer model
   // ------------------------------------------------------------------
   function automatic void enter_phase(phase_type next_ph, logic [BYTE_W-1:0] load);
      seq_ph     = next_ph;
      bit_pos    = '0;
      half_count = '0;
      shift_byte = load;
   endfunction

   function automatic bit is_shift_phase(phase_type p);
      return p == PH_TX_DEVW || p == PH_TX_REG || p == PH_TX_DATA || p == PH_TX_DEVR;
   endfunction

   function automatic bit is_ack_phase(phase_type p);
      return p == PH_ACK_DEVW || p == PH_ACK_REG || p == PH_ACK_DATA ||
             p == PH_ACK_DEVR || p == PH_ACK_LAST;
   endfunction

   // One tick: bus levels come from the phase at the start of the tick,
   // read byte and ack sample from after this tick's SDA sample.
   function automatic result_type advance_sequencer(item_type it);
      result_type  lv;
      int unsigned half_len;
      bit          upper;
      lv       = IDLE_BUS;
      half_len = (cfg_half_ticks == '0) ? 1 : cfg_half_ticks;
      if (seq_ph == PH_IDLE && (it.cmd == CMD_WRITE || it.cmd == CMD_READ)) begin
         access_is_read = (it.cmd == CMD_READ);
         latched_reg    = it.reg_addr;
         latched_data   = it.write_data;
         enter_phase(PH_START1, 8'h00);
      end
      lv.busy_res = (seq_ph != PH_IDLE);
      upper       = bit_pos[0];   // odd half-bit index = SCL high half

      if (is_shift_phase(seq_ph)) begin
         lv.scl_level    = upper;
         lv.sda_pull_low = ~shift_byte[7];
      end else if (is_ack_phase(seq_ph) || seq_ph == PH_RX) begin
         lv.scl_level = upper;
      end else begin
         case (seq_ph)
            PH_START2, PH_RS2, PH_STOP1: lv.sda_pull_low = 1'b1;
            PH_RS0: lv.scl_level = 1'b0;
            PH_STOP0: begin
               lv.scl_level    = 1'b0;
               lv.sda_pull_low = 1'b1;
            end
            default: ;
         endcase
      end

      if (seq_ph != PH_IDLE) begin
         if (half_count + 1 < half_len) begin
            half_count = half_count + 1'b1;
         end else if (is_shift_phase(seq_ph) || seq_ph == PH_RX) begin
            // byte moves on at the end of each high half
            if (upper)
               shift_byte = {shift_byte[6:0], (seq_ph == PH_RX) ? it.sda_in : 1'b0};
            if (bit_pos != LAST_BIT) begin
               bit_pos    = bit_pos + 1'b1;
               half_count = '0;
            end else begin
               if (seq_ph == PH_RX)
                  rx_byte = shift_byte;
               enter_phase(phase_type'(seq_ph + 1), 8'h00);
            end
         end else if (is_ack_phase(seq_ph)) begin
            if (bit_pos == '0) begin
               bit_pos    = BIT_W'(1);
               half_count = '0;
            end else begin
               ack_level = it.sda_in;
               case (seq_ph)
                  PH_ACK_DEVW: enter_phase(PH_TX_REG, latched_reg);
                  PH_ACK_REG:
                     if (access_is_read) enter_phase(PH_RS0, 8'h00);
                     else enter_phase(PH_TX_DATA, latched_data);
                  PH_ACK_DEVR: enter_phase(PH_RX, 8'h00);
                  default: enter_phase(PH_STOP0, 8'h00);
               endcase
            end
         end else begin
            case (seq_ph)
               PH_START2: enter_phase(PH_TX_DEVW, {cfg_dev_addr, 1'b0});
               PH_RS2:    enter_phase(PH_TX_DEVR, {cfg_dev_addr, 1'b1});
               PH_STOP2: begin
                  enter_phase(PH_IDLE, 8'h00);
                  lv.done_res = 1'b1;
               end
               default: enter_phase(phase_type'(seq_ph + 1), 8'h00);
            endcase
         end
      end

      lv.read_data = rx_byte;
      lv.last_ack  = ack_level;
      return lv;
   endfunction

   // Random tick: on an idle bus mostly a new access, while busy mostly a
   // plain tick with now and then a stray command that must be ignored.
   function automatic item_type next_tick();
      item_type it;
      it.reg_addr   = BYTE_W'($urandom);
      it.write_data = BYTE_W'($urandom);
      it.sda_in     = 1'($urandom_range(0, 1));
      if (seq_ph == PH_IDLE) begin
         case ($urandom_range(0, 9))
            0:          it.cmd = CMD_TICK;
            1:          it.cmd = CMD_RSVD;
            2, 3, 4, 5: it.cmd = CMD_WRITE;
            default:    it.cmd = CMD_READ;
         endcase
      end else begin
         if ($urandom_range(0, 7) == 0)
            it.cmd = CMD_W'($urandom_range(0, 3));
         else
            it.cmd = CMD_TICK;
      end
      return it;
   endfunction

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   task automatic send_request(item_type it, bit typed, result_type want);
      result_type lv;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, it.sda_in, it.write_data, it.reg_addr, it.cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // model always advances, a typed row only overrides what is checked
      lv = advance_sequencer(it);
      pending_bus_levels.push_back(typed ? want : lv);
   endtask

   task automatic pause_requests(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   // stop offering and wait until every response is back
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_bus_levels.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(logic [ADDR_W-1:0] dev, logic [TICKS_W-1:0] ticks);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEVICE_ADDRESS;
      csr_wdata <= TICKS_W'(dev);
      @(negedge clock);
      csr_index <= CSR_PHASE_TICKS;
      csr_wdata <= ticks;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg_dev_addr   = dev;
      cfg_half_ticks = ticks;
   endtask

   initial begin : stimulus
      int unsigned left;
      int unsigned burst;
      while (reset) @(posedge clock);

      foreach (opening_rows[r])
         send_request(opening_rows[r].req, opening_rows[r].typed, opening_rows[r].want);

      // Random part: sender in bursts, gaps between most of them.
      // Sequencer is usually mid-access at a config change; that is fine,
      // only the stream must be empty.
      foreach (sweep[s]) begin
         wait_idle();
         set_config(sweep[s].dev, sweep[s].ticks);
         if (s == 0)
            hold_request = 1'b1;
         left = sweep[s].count;
         while (left > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && left > 0) begin
               send_request(next_tick(), 1'b0, IDLE_BUS);
               burst--;
               left--;
            end
            if ($urandom_range(0, 3) != 0)
               pause_requests($urandom_range(1, 6));
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------
   // Stall pattern changes every span: always ready, coin flip, ready one
   // cycle in k, mostly ready. One long hold-off while the sender keeps
   // going, so the core fills up and drops req_tready.
   initial begin : rsp_pacing
      int unsigned mode;
      int unsigned span;
      int unsigned k;
      forever begin
         if (hold_request) begin
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
            hold_request = 1'b0;
         end
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 160);
         k    = $urandom_range(2, 5);
         for (int c = 0; c < span; c++) begin
            @(negedge clock);
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= (c % k == 0);
               default: rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_monitor
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_W-1:0];
         if (pending_bus_levels.size() == 0) begin
            $error("response with no request pending: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_bus_levels.pop_front();
            check_field("scl_level",    8'(want.scl_level),    8'(got.scl_level));
            check_field("sda_pull_low", 8'(want.sda_pull_low), 8'(got.sda_pull_low));
            check_field("busy_res",     8'(want.busy_res),     8'(got.busy_res));
            check_field("done_res",     8'(want.done_res),     8'(got.done_res));
            check_field("read_data",    want.read_data,        got.read_data);
            check_field("last_ack",     8'(want.last_ack),     8'(got.last_ack));
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

endmodule
